/* rtl/r2rc_pkg.sv */
// Package with the opcodes, funct codes and result type of the RV32I to RVC compressor.
`timescale 1ns / 1ps

package r2rc_pkg;

    // Major opcodes of the RV32I formats that the compressor recognises.
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_JAL    = 7'h6F;

    // funct3 codes.
    localparam logic [2:0] F3_ADD_SUB = 3'd0;
    localparam logic [2:0] F3_SLL     = 3'd1;
    localparam logic [2:0] F3_WORD    = 3'd2;
    localparam logic [2:0] F3_XOR     = 3'd4;
    localparam logic [2:0] F3_SRL_SRA = 3'd5;
    localparam logic [2:0] F3_OR      = 3'd6;
    localparam logic [2:0] F3_AND     = 3'd7;
    localparam logic [2:0] F3_BEQ     = 3'd0;
    localparam logic [2:0] F3_BNE     = 3'd1;

    // funct7 codes.
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct2 codes of the compressed register-register ALU group.
    localparam logic [1:0] CF2_SUB = 2'd0;
    localparam logic [1:0] CF2_XOR = 2'd1;
    localparam logic [1:0] CF2_OR  = 2'd2;
    localparam logic [1:0] CF2_AND = 2'd3;

    // funct3 codes of the compressed branch and jump forms.
    localparam logic [2:0] CF3_BEQZ = 3'b110;
    localparam logic [2:0] CF3_BNEZ = 3'b111;
    localparam logic [2:0] CF3_J    = 3'b101;
    localparam logic [2:0] CF3_JAL  = 3'b001;

    // Register numbers with a special meaning.
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;

    // One result word.
    typedef struct packed {
        logic        can_compress;
        logic [15:0] half_word;
        logic        format_error;
    } t_rvc_result;

    // True for x8..x15, the registers reachable by the three-bit RVC fields.
    function automatic logic is_prime_reg(input logic [4:0] r);
        is_prime_reg = (r[4:3] == 2'b01);
    endfunction

endpackage

/* rtl/r2rc_encoder.sv */
// Combinational decode of one RV32I word and re-encode into its RVC halfword.
`timescale 1ns / 1ps

module r2rc_encoder (
    input  logic [31:0]          i_word,
    output r2rc_pkg::t_rvc_result o_result
);

    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic [11:0] iraw;
    logic [11:0] sraw;
    logic [12:0] br_off;
    logic [20:0] jal_off;
    logic [19:0] upper;
    logic        imm_small;
    logic        rd_eq_rs1;
    logic        rd_prime;
    logic        rs1_prime;
    logic        rs2_prime;
    logic [1:0]  alu_f2;
    logic        alu_ok;
    logic        hit;
    logic [15:0] hw;
    logic        fmt_err;

    // Split the word into its standard fields.
    assign opcode  = i_word[6:0];
    assign rd      = i_word[11:7];
    assign f3      = i_word[14:12];
    assign rs1     = i_word[19:15];
    assign rs2     = i_word[24:20];
    assign f7      = i_word[31:25];
    assign iraw    = i_word[31:20];
    assign sraw    = {i_word[31:25], i_word[11:7]};
    assign br_off  = {i_word[31], i_word[7], i_word[30:25], i_word[11:8], 1'b0};
    assign jal_off = {i_word[31], i_word[19:12], i_word[20], i_word[30:21], 1'b0};
    assign upper   = i_word[31:12];

    // Shared checks: a six-bit signed immediate, register equality and prime registers.
    assign imm_small = (iraw[11:5] == 7'h00) || (iraw[11:5] == 7'h7F);
    assign rd_eq_rs1 = (rd == rs1);
    assign rd_prime  = r2rc_pkg::is_prime_reg(rd);
    assign rs1_prime = r2rc_pkg::is_prime_reg(rs1);
    assign rs2_prime = r2rc_pkg::is_prime_reg(rs2);

    // Select the compressed ALU funct2 for sub, xor, or and and.
    always_comb begin
        alu_f2 = r2rc_pkg::CF2_SUB;
        alu_ok = 1'b0;
        priority if (f3 == r2rc_pkg::F3_ADD_SUB && f7 == r2rc_pkg::F7_ALT) begin
            alu_f2 = r2rc_pkg::CF2_SUB;
            alu_ok = 1'b1;
        end else if (f3 == r2rc_pkg::F3_XOR && f7 == r2rc_pkg::F7_BASE) begin
            alu_f2 = r2rc_pkg::CF2_XOR;
            alu_ok = 1'b1;
        end else if (f3 == r2rc_pkg::F3_OR && f7 == r2rc_pkg::F7_BASE) begin
            alu_f2 = r2rc_pkg::CF2_OR;
            alu_ok = 1'b1;
        end else if (f3 == r2rc_pkg::F3_AND && f7 == r2rc_pkg::F7_BASE) begin
            alu_f2 = r2rc_pkg::CF2_AND;
            alu_ok = 1'b1;
        end else begin
            alu_ok = 1'b0;
        end
    end

    // Main decode: pick the matching RVC form for each major opcode.
    always_comb begin
        hit     = 1'b0;
        hw      = 16'h0000;
        fmt_err = 1'b0;
        unique case (opcode)
            r2rc_pkg::OP_REG: begin
                if (f3 == r2rc_pkg::F3_ADD_SUB && f7 == r2rc_pkg::F7_BASE) begin
                    // C.ADD takes priority over C.MV.
                    priority if (rd_eq_rs1 && rd != r2rc_pkg::REG_ZERO
                                 && rs2 != r2rc_pkg::REG_ZERO) begin
                        hit = 1'b1;
                        hw  = {4'b1001, rd, rs2, 2'b10};
                    end else if (rs1 == r2rc_pkg::REG_ZERO && rd != r2rc_pkg::REG_ZERO
                                 && rs2 != r2rc_pkg::REG_ZERO) begin
                        hit = 1'b1;
                        hw  = {4'b1000, rd, rs2, 2'b10};
                    end else begin
                        hit = 1'b0;
                    end
                end else if (alu_ok && rd_eq_rs1 && rd_prime && rs2_prime) begin
                    hit = 1'b1;
                    hw  = {6'b100011, rd[2:0], alu_f2, rs2[2:0], 2'b01};
                end
            end
            r2rc_pkg::OP_IMM: begin
                unique case (f3)
                    r2rc_pkg::F3_ADD_SUB: begin
                        // C.LI when the source is x0, otherwise C.ADDI with a non-zero immediate.
                        if (imm_small) begin
                            priority if (rd != r2rc_pkg::REG_ZERO
                                         && rs1 == r2rc_pkg::REG_ZERO) begin
                                hit = 1'b1;
                                hw  = {3'b010, iraw[5], rd, iraw[4:0], 2'b01};
                            end else if (rd_eq_rs1 && rd != r2rc_pkg::REG_ZERO
                                         && iraw != 12'h000) begin
                                hit = 1'b1;
                                hw  = {3'b000, iraw[5], rd, iraw[4:0], 2'b01};
                            end else begin
                                hit = 1'b0;
                            end
                        end
                    end
                    r2rc_pkg::F3_SLL: begin
                        if (f7 == r2rc_pkg::F7_BASE && rd_eq_rs1
                            && rd != r2rc_pkg::REG_ZERO) begin
                            hit = 1'b1;
                            hw  = {4'b0000, rd, iraw[4:0], 2'b10};
                        end
                    end
                    r2rc_pkg::F3_SRL_SRA: begin
                        if (rd_eq_rs1 && rd_prime) begin
                            if (f7 == r2rc_pkg::F7_BASE) begin
                                hit = 1'b1;
                                hw  = {6'b100000, rd[2:0], iraw[4:0], 2'b01};
                            end else if (f7 == r2rc_pkg::F7_ALT) begin
                                hit = 1'b1;
                                hw  = {6'b100001, rd[2:0], iraw[4:0], 2'b01};
                            end
                        end
                    end
                    r2rc_pkg::F3_AND: begin
                        if (rd_eq_rs1 && rd_prime && imm_small) begin
                            hit = 1'b1;
                            hw  = {3'b100, iraw[5], 2'b10, rd[2:0], iraw[4:0], 2'b01};
                        end
                    end
                    default: begin
                        hit = 1'b0;
                    end
                endcase
            end
            r2rc_pkg::OP_JALR: begin
                if (f3 == r2rc_pkg::F3_ADD_SUB && rs1 != r2rc_pkg::REG_ZERO
                    && iraw == 12'h000) begin
                    if (rd == r2rc_pkg::REG_ZERO) begin
                        hit = 1'b1;
                        hw  = {4'b1000, rs1, 5'b00000, 2'b10};
                    end else if (rd == r2rc_pkg::REG_RA) begin
                        hit = 1'b1;
                        hw  = {4'b1001, rs1, 5'b00000, 2'b10};
                    end
                end
            end
            r2rc_pkg::OP_LOAD: begin
                // Word-aligned offset from 0 to 124.
                if (f3 == r2rc_pkg::F3_WORD && rd_prime && rs1_prime
                    && iraw[11:7] == 5'd0 && iraw[1:0] == 2'd0) begin
                    hit = 1'b1;
                    hw  = {3'b010, iraw[5:3], rs1[2:0], iraw[2], iraw[6], rd[2:0], 2'b00};
                end
            end
            r2rc_pkg::OP_STORE: begin
                if (f3 == r2rc_pkg::F3_WORD && rs1_prime && rs2_prime
                    && sraw[11:7] == 5'd0 && sraw[1:0] == 2'd0) begin
                    hit = 1'b1;
                    hw  = {3'b110, sraw[5:3], rs1[2:0], sraw[2], sraw[6], rs2[2:0], 2'b00};
                end
            end
            r2rc_pkg::OP_BRANCH: begin
                // Compare against x0 only, offset within -256..254.
                if ((f3 == r2rc_pkg::F3_BEQ || f3 == r2rc_pkg::F3_BNE)
                    && rs2 == r2rc_pkg::REG_ZERO && rs1_prime
                    && (br_off[12:8] == 5'h00 || br_off[12:8] == 5'h1F)) begin
                    hit = 1'b1;
                    hw  = {(f3 == r2rc_pkg::F3_BEQ) ? r2rc_pkg::CF3_BEQZ : r2rc_pkg::CF3_BNEZ,
                           br_off[8], br_off[4:3], rs1[2:0], br_off[7:6], br_off[2:1],
                           br_off[5], 2'b01};
                end
            end
            r2rc_pkg::OP_LUI: begin
                if (rd != r2rc_pkg::REG_ZERO && rd != r2rc_pkg::REG_SP && upper != 20'h0
                    && (upper[19:5] == 15'h0000 || upper[19:5] == 15'h7FFF)) begin
                    hit = 1'b1;
                    hw  = {3'b011, upper[5], rd, upper[4:0], 2'b01};
                end
            end
            r2rc_pkg::OP_JAL: begin
                // Link to x0 or ra only, offset within -2048..2046.
                if ((rd == r2rc_pkg::REG_ZERO || rd == r2rc_pkg::REG_RA)
                    && (jal_off[20:11] == 10'h000 || jal_off[20:11] == 10'h3FF)) begin
                    hit = 1'b1;
                    hw  = {(rd == r2rc_pkg::REG_ZERO) ? r2rc_pkg::CF3_J : r2rc_pkg::CF3_JAL,
                           jal_off[11], jal_off[4], jal_off[9:8], jal_off[10], jal_off[6],
                           jal_off[7], jal_off[3:1], jal_off[5], 2'b01};
                end
            end
            default: begin
                fmt_err = 1'b1;
            end
        endcase
    end

    // The halfword reads as zero whenever no compressed form applies.
    assign o_result.can_compress = hit;
    assign o_result.half_word    = hit ? hw : 16'h0000;
    assign o_result.format_error = fmt_err;

endmodule

/* rtl/rv32_to_rvc_compressor_core.sv */
// Top level of the RV32I to RVC compressor: input register, encoder and result register.
// Path: an accepted word is held in the input register, encoded, and then held in the result register.
// Throughput: one word per cycle while the receiver does not stall; the encoder between the two registers is one pass.
// The result register accepts a new word while it is empty or being taken; the input register also while it is empty.
// Reset (synchronous, active low) empties both registers; no other state is kept.
`timescale 1ns / 1ps

module rv32_to_rvc_compressor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instr_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_can_compress,
    output logic [15:0] o_half_word,
    output logic        o_format_error
);

    logic                  r_in_valid;
    logic                  n_in_valid;
    logic [31:0]           r_in_word;
    logic                  r_out_valid;
    logic                  n_out_valid;
    r2rc_pkg::t_rvc_result r_out_result;
    r2rc_pkg::t_rvc_result enc_result;
    logic                  out_free;
    logic                  in_free;

    // A stage may load when it is empty or its word moves on in the same cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_free    = !r_in_valid || out_free;
    assign o_in_stall = !in_free;

    assign n_in_valid  = in_free ? i_in_valid : r_in_valid;
    assign n_out_valid = out_free ? r_in_valid : r_out_valid;

    // Decode and re-encode the registered word.
    r2rc_encoder u_encoder (
        .i_word   (r_in_word),
        .o_result (enc_result)
    );

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers hold while their stage is stalled.
    always_ff @(posedge i_clk) begin
        if (in_free) begin
            r_in_word <= i_instr_word;
        end
        if (out_free) begin
            r_out_result <= enc_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_can_compress = r_out_result.can_compress;
    assign o_half_word    = r_out_result.half_word;
    assign o_format_error = r_out_result.format_error;

endmodule

/* test/tb.sv */
// Self-checking testbench for the RV32I to RVC compressor core.
`timescale 1ns / 1ps

module tb;

    // Result rows for the cases that need no working out.
    localparam r2rc_pkg::t_rvc_result FMT_ERR = '{can_compress: 1'b0, half_word: 16'h0000,
                                                  format_error: 1'b1};
    localparam r2rc_pkg::t_rvc_result NO_RVC  = '{can_compress: 1'b0, half_word: 16'h0000,
                                                  format_error: 1'b0};

    localparam logic [6:0] KNOWN_OPS [8] = '{r2rc_pkg::OP_REG, r2rc_pkg::OP_IMM,
                                             r2rc_pkg::OP_JALR, r2rc_pkg::OP_LOAD,
                                             r2rc_pkg::OP_STORE, r2rc_pkg::OP_BRANCH,
                                             r2rc_pkg::OP_LUI, r2rc_pkg::OP_JAL};

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct packed {
        logic [31:0]           word;
        logic                  typed;
        r2rc_pkg::t_rvc_result res;
    } t_dir_row;

    // One pending result, with the word that caused it.
    typedef struct packed {
        logic [31:0]           word;
        r2rc_pkg::t_rvc_result res;
    } t_pending_rvc;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_instr_word = 32'h0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_can_compress;
    logic [15:0] o_half_word;
    logic        o_format_error;

    t_pending_rvc          rvc_expected[$];
    int                    mismatch_count = 0;
    int                    src_idle_pct = 0;
    int                    sink_stall_pct = 0;
    logic                  cur_typed = 1'b0;
    r2rc_pkg::t_rvc_result cur_typed_res = '0;

    rv32_to_rvc_compressor_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_instr_word   (i_instr_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_can_compress (o_can_compress),
        .o_half_word    (o_half_word),
        .o_format_error (o_format_error)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Registers x8 to x15 are the only ones the three-bit RVC fields reach.
    function automatic logic rvc_reg(input logic [4:0] r);
        return (r >= 5'd8) && (r <= 5'd15);
    endfunction

    // Works out the compressed form of one RV32I word.
    function automatic r2rc_pkg::t_rvc_result rvc_encode(input logic [31:0] w);
        logic [6:0]  op, f7;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3, cf;
        logic [1:0]  f2;
        logic [11:0] ir, sr;
        logic [12:0] bo;
        logic [20:0] jo;
        logic [19:0] u;
        int          imm, simm, boff, joff, uv;
        logic        ok;
        logic [15:0] h;
        r2rc_pkg::t_rvc_result r;
        op = w[6:0];
        rd = w[11:7];
        f3 = w[14:12];
        rs1 = w[19:15];
        rs2 = w[24:20];
        f7 = w[31:25];
        ir = w[31:20];
        sr = {w[31:25], w[11:7]};
        bo = {w[31], w[7], w[30:25], w[11:8], 1'b0};
        jo = {w[31], w[19:12], w[20], w[30:21], 1'b0};
        u = w[31:12];
        imm = $signed(ir);
        simm = $signed(sr);
        boff = $signed(bo);
        joff = $signed(jo);
        uv = $signed(u);
        ok = 1'b0;
        h = '0;
        f2 = r2rc_pkg::CF2_SUB;
        cf = r2rc_pkg::CF3_J;
        r = NO_RVC;
        case (op)
            r2rc_pkg::OP_REG: begin
                if (f3 == r2rc_pkg::F3_ADD_SUB && f7 == r2rc_pkg::F7_BASE) begin
                    // Plain add: C.ADD when rd is also the source, C.MV from x0.
                    if (rd == rs1 && rd != r2rc_pkg::REG_ZERO
                        && rs2 != r2rc_pkg::REG_ZERO) begin
                        ok = 1'b1;
                        h = {4'b1001, rd, rs2, 2'b10};
                    end else if (rs1 == r2rc_pkg::REG_ZERO && rd != r2rc_pkg::REG_ZERO
                                 && rs2 != r2rc_pkg::REG_ZERO) begin
                        ok = 1'b1;
                        h = {4'b1000, rd, rs2, 2'b10};
                    end
                end else begin
                    ok = 1'b1;
                    if (f3 == r2rc_pkg::F3_ADD_SUB && f7 == r2rc_pkg::F7_ALT)
                        f2 = r2rc_pkg::CF2_SUB;
                    else if (f3 == r2rc_pkg::F3_XOR && f7 == r2rc_pkg::F7_BASE)
                        f2 = r2rc_pkg::CF2_XOR;
                    else if (f3 == r2rc_pkg::F3_OR && f7 == r2rc_pkg::F7_BASE)
                        f2 = r2rc_pkg::CF2_OR;
                    else if (f3 == r2rc_pkg::F3_AND && f7 == r2rc_pkg::F7_BASE)
                        f2 = r2rc_pkg::CF2_AND;
                    else ok = 1'b0;
                    if (!(rd == rs1 && rvc_reg(rd) && rvc_reg(rs2))) ok = 1'b0;
                    h = {6'b100011, rd[2:0], f2, rs2[2:0], 2'b01};
                end
            end
            r2rc_pkg::OP_IMM: begin
                if (f3 == r2rc_pkg::F3_ADD_SUB) begin
                    if (imm >= -32 && imm <= 31) begin
                        if (rd != r2rc_pkg::REG_ZERO && rs1 == r2rc_pkg::REG_ZERO) begin
                            ok = 1'b1;
                            h = {3'b010, ir[5], rd, ir[4:0], 2'b01};
                        end else if (rd == rs1 && rd != r2rc_pkg::REG_ZERO && imm != 0) begin
                            ok = 1'b1;
                            h = {3'b000, ir[5], rd, ir[4:0], 2'b01};
                        end
                    end
                end else if (f3 == r2rc_pkg::F3_SLL) begin
                    ok = (f7 == r2rc_pkg::F7_BASE) && (rd == rs1) && (rd != r2rc_pkg::REG_ZERO);
                    h = {4'b0000, rd, ir[4:0], 2'b10};
                end else if (f3 == r2rc_pkg::F3_SRL_SRA) begin
                    ok = (rd == rs1) && rvc_reg(rd)
                         && (f7 == r2rc_pkg::F7_BASE || f7 == r2rc_pkg::F7_ALT);
                    h = {5'b10000, f7 == r2rc_pkg::F7_ALT, rd[2:0], ir[4:0], 2'b01};
                end else if (f3 == r2rc_pkg::F3_AND) begin
                    ok = (rd == rs1) && rvc_reg(rd) && imm >= -32 && imm <= 31;
                    h = {3'b100, ir[5], 2'b10, rd[2:0], ir[4:0], 2'b01};
                end
            end
            r2rc_pkg::OP_JALR: begin
                // Only a zero offset from a non-zero base, linking to x0 or ra.
                if (f3 == r2rc_pkg::F3_ADD_SUB && rs1 != r2rc_pkg::REG_ZERO && imm == 0) begin
                    ok = (rd == r2rc_pkg::REG_ZERO) || (rd == r2rc_pkg::REG_RA);
                    h = {3'b100, rd == r2rc_pkg::REG_RA, rs1, 5'd0, 2'b10};
                end
            end
            r2rc_pkg::OP_LOAD: begin
                ok = (f3 == r2rc_pkg::F3_WORD) && rvc_reg(rd) && rvc_reg(rs1) &&
                     imm >= 0 && imm <= 124 && ir[1:0] == 2'b00;
                h = {3'b010, ir[5:3], rs1[2:0], ir[2], ir[6], rd[2:0], 2'b00};
            end
            r2rc_pkg::OP_STORE: begin
                ok = (f3 == r2rc_pkg::F3_WORD) && rvc_reg(rs1) && rvc_reg(rs2) &&
                     simm >= 0 && simm <= 124 && sr[1:0] == 2'b00;
                h = {3'b110, sr[5:3], rs1[2:0], sr[2], sr[6], rs2[2:0], 2'b00};
            end
            r2rc_pkg::OP_BRANCH: begin
                if (f3 == r2rc_pkg::F3_BEQ || f3 == r2rc_pkg::F3_BNE) begin
                    cf = (f3 == r2rc_pkg::F3_BEQ) ? r2rc_pkg::CF3_BEQZ : r2rc_pkg::CF3_BNEZ;
                    ok = (rs2 == r2rc_pkg::REG_ZERO) && rvc_reg(rs1)
                         && boff >= -256 && boff <= 254;
                    h = {cf, bo[8], bo[4:3], rs1[2:0], bo[7:6], bo[2:1], bo[5], 2'b01};
                end
            end
            r2rc_pkg::OP_LUI: begin
                ok = (rd != r2rc_pkg::REG_ZERO) && (rd != r2rc_pkg::REG_SP) && (u != 20'h0) &&
                     uv >= -32 && uv <= 31;
                h = {3'b011, u[5], rd, u[4:0], 2'b01};
            end
            r2rc_pkg::OP_JAL: begin
                if (rd == r2rc_pkg::REG_ZERO || rd == r2rc_pkg::REG_RA) begin
                    cf = (rd == r2rc_pkg::REG_ZERO) ? r2rc_pkg::CF3_J : r2rc_pkg::CF3_JAL;
                    ok = joff >= -2048 && joff <= 2046;
                    h = {cf, jo[11], jo[4], jo[9:8], jo[10], jo[6], jo[7], jo[3:1], jo[5],
                         2'b01};
                end
            end
            default: begin
                r.format_error = 1'b1;
            end
        endcase
        if (ok) begin
            r.can_compress = 1'b1;
            r.half_word = h;
        end
        return r;
    endfunction

    // Builds a branch word from a byte offset.
    function automatic logic [31:0] branch_word(input int off, input logic [4:0] rs1,
                                                input logic [4:0] rs2, input logic [2:0] f3);
        logic [12:0] o;
        o = off[12:0];
        return {o[12], o[10:5], rs2, rs1, f3, o[4:1], o[11], r2rc_pkg::OP_BRANCH};
    endfunction

    // Builds a jal word from a byte offset.
    function automatic logic [31:0] jal_word(input int off, input logic [4:0] rd);
        logic [20:0] o;
        o = off[20:0];
        return {o[20], o[10:1], o[11], o[19:12], rd, r2rc_pkg::OP_JAL};
    endfunction

    // Register choice leaning towards x8..x15 and the special low registers.
    function automatic logic [4:0] pick_reg();
        case ($urandom_range(3))
            0, 1:    return 5'(8 + $urandom_range(7));
            2:       return 5'($urandom_range(2));
            default: return 5'($urandom);
        endcase
    endfunction

    // Immediate choice leaning towards the ranges the RVC forms accept.
    function automatic logic [11:0] pick_imm12();
        case ($urandom_range(3))
            0:       return 12'(int'($urandom_range(63)) - 32);
            1:       return 12'($urandom_range(31) * 4);
            2:       return 12'd0;
            default: return 12'($urandom);
        endcase
    endfunction

    // Offers one word and holds it until the core takes it, then returns at a falling edge.
    task automatic issue_word(input logic [31:0] w, input logic typed,
                              input r2rc_pkg::t_rvc_result res);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_typed = typed;
        cur_typed_res = res;
        i_in_valid <= 1'b1;
        i_instr_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got, input logic [31:0] w);
        if (want !== got) begin
            $display("%0t: word %h, %s expected %h, got %h", $time, w, name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Records each accepted word and checks each accepted result against the oldest one.
    always @(posedge i_clk) begin
        t_pending_rvc head;
        if (o_out_valid === 1'b1 && !i_out_stall) begin
            if (rvc_expected.size() == 0) begin
                $display("%0t: result %b/%h/%b with none expected", $time,
                         o_can_compress, o_half_word, o_format_error);
                mismatch_count++;
            end else begin
                head = rvc_expected.pop_front();
                check_field("can_compress", 16'(head.res.can_compress), 16'(o_can_compress),
                            head.word);
                check_field("half_word", head.res.half_word, o_half_word, head.word);
                check_field("format_error", 16'(head.res.format_error), 16'(o_format_error),
                            head.word);
            end
        end
        if (i_in_valid && !o_in_stall) begin
            rvc_expected.push_back('{word: i_instr_word,
                                     res: cur_typed ? cur_typed_res : rvc_encode(i_instr_word)});
        end
    end

    // Stimulus: directed table, a drain, then random words under four idling mixes.
    initial begin : stimulus
        t_dir_row    dir_rows [25];
        logic [31:0] w;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [11:0] imm;
        int          off;
        int          phase;
        dir_rows = '{
            '{32'h0000_0000, 1'b1, FMT_ERR},
            '{32'hFFFF_FFFF, 1'b1, FMT_ERR},
            '{32'h0000_0017, 1'b1, FMT_ERR},
            '{32'h0000_000F, 1'b1, FMT_ERR},
            '{{12'd0, r2rc_pkg::REG_ZERO, r2rc_pkg::F3_ADD_SUB, r2rc_pkg::REG_ZERO,
               r2rc_pkg::OP_IMM}, 1'b1, NO_RVC},
            '{{r2rc_pkg::F7_BASE, 5'd2, 5'd1, r2rc_pkg::F3_ADD_SUB, 5'd1, r2rc_pkg::OP_REG},
              1'b0, NO_RVC},
            '{{r2rc_pkg::F7_BASE, 5'd6, r2rc_pkg::REG_ZERO, r2rc_pkg::F3_ADD_SUB, 5'd5,
               r2rc_pkg::OP_REG}, 1'b0, NO_RVC},
            '{{r2rc_pkg::F7_ALT, 5'd9, 5'd8, r2rc_pkg::F3_ADD_SUB, 5'd8, r2rc_pkg::OP_REG},
              1'b0, NO_RVC},
            '{{r2rc_pkg::F7_BASE, 5'd15, 5'd10, r2rc_pkg::F3_XOR, 5'd10, r2rc_pkg::OP_REG},
              1'b0, NO_RVC},
            '{{r2rc_pkg::F7_BASE, 5'd8, 5'd15, r2rc_pkg::F3_OR, 5'd15, r2rc_pkg::OP_REG},
              1'b0, NO_RVC},
            '{{r2rc_pkg::F7_BASE, 5'd12, 5'd9, r2rc_pkg::F3_AND, 5'd9, r2rc_pkg::OP_REG},
              1'b0, NO_RVC},
            '{{12'hFE0, r2rc_pkg::REG_ZERO, r2rc_pkg::F3_ADD_SUB, 5'd5, r2rc_pkg::OP_IMM},
              1'b0, NO_RVC},
            '{{12'd31, 5'd7, r2rc_pkg::F3_ADD_SUB, 5'd7, r2rc_pkg::OP_IMM}, 1'b0, NO_RVC},
            '{{12'd0, 5'd1, r2rc_pkg::F3_ADD_SUB, r2rc_pkg::REG_ZERO, r2rc_pkg::OP_JALR},
              1'b0, NO_RVC},
            '{{12'd0, 5'd31, r2rc_pkg::F3_ADD_SUB, r2rc_pkg::REG_RA, r2rc_pkg::OP_JALR},
              1'b0, NO_RVC},
            '{{r2rc_pkg::F7_BASE, 5'd0, 5'd3, r2rc_pkg::F3_SLL, 5'd3, r2rc_pkg::OP_IMM},
              1'b0, NO_RVC},
            '{{r2rc_pkg::F7_BASE, 5'd31, 5'd8, r2rc_pkg::F3_SRL_SRA, 5'd8, r2rc_pkg::OP_IMM},
              1'b0, NO_RVC},
            '{{r2rc_pkg::F7_ALT, 5'd1, 5'd15, r2rc_pkg::F3_SRL_SRA, 5'd15, r2rc_pkg::OP_IMM},
              1'b0, NO_RVC},
            '{{12'hFFF, 5'd9, r2rc_pkg::F3_AND, 5'd9, r2rc_pkg::OP_IMM}, 1'b0, NO_RVC},
            '{{12'd124, 5'd15, r2rc_pkg::F3_WORD, 5'd8, r2rc_pkg::OP_LOAD}, 1'b0, NO_RVC},
            '{{7'd3, 5'd9, 5'd8, r2rc_pkg::F3_WORD, 5'd28, r2rc_pkg::OP_STORE}, 1'b0, NO_RVC},
            '{branch_word(-256, 5'd8, r2rc_pkg::REG_ZERO, r2rc_pkg::F3_BEQ), 1'b0, NO_RVC},
            '{branch_word(254, 5'd15, r2rc_pkg::REG_ZERO, r2rc_pkg::F3_BNE), 1'b0, NO_RVC},
            '{{20'hFFFFF, 5'd3, r2rc_pkg::OP_LUI}, 1'b0, NO_RVC},
            '{jal_word(2046, r2rc_pkg::REG_RA), 1'b0, NO_RVC}
        };

        // Synchronous reset held from the start, released at a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            issue_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].res);
        end
        issue_word(jal_word(-2048, r2rc_pkg::REG_ZERO), 1'b0, NO_RVC);

        // Hold the sender off until every outstanding result has come back.
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (rvc_expected.size() != 0) @(negedge i_clk);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
                default: begin src_idle_pct = 21; sink_stall_pct = 21; end
            endcase
            repeat (175) begin
                rd = pick_reg();
                rs1 = $urandom_range(1) ? rd : pick_reg();
                rs2 = pick_reg();
                imm = pick_imm12();
                case ($urandom_range(2))
                    0:       f7 = r2rc_pkg::F7_BASE;
                    1:       f7 = r2rc_pkg::F7_ALT;
                    default: f7 = 7'($urandom);
                endcase
                case ($urandom_range(9))
                    0: begin
                        case ($urandom_range(4))
                            0: f3 = r2rc_pkg::F3_ADD_SUB;
                            1: f3 = r2rc_pkg::F3_XOR;
                            2: f3 = r2rc_pkg::F3_OR;
                            3: f3 = r2rc_pkg::F3_AND;
                            default: f3 = 3'($urandom);
                        endcase
                        w = {f7, rs2, rs1, f3, rd, r2rc_pkg::OP_REG};
                    end
                    1: begin
                        case ($urandom_range(4))
                            0: f3 = r2rc_pkg::F3_ADD_SUB;
                            1: f3 = r2rc_pkg::F3_SLL;
                            2: f3 = r2rc_pkg::F3_SRL_SRA;
                            3: f3 = r2rc_pkg::F3_AND;
                            default: f3 = 3'($urandom);
                        endcase
                        // Shifts carry funct7 in the top of the immediate.
                        if (f3 == r2rc_pkg::F3_SLL || f3 == r2rc_pkg::F3_SRL_SRA)
                            imm[11:5] = f7;
                        w = {imm, rs1, f3, rd, r2rc_pkg::OP_IMM};
                    end
                    2: begin
                        if ($urandom_range(3) != 0) imm = 12'd0;
                        f3 = ($urandom_range(3) != 0) ? r2rc_pkg::F3_ADD_SUB : 3'($urandom);
                        case ($urandom_range(2))
                            0: rd = r2rc_pkg::REG_ZERO;
                            1: rd = r2rc_pkg::REG_RA;
                            default: rd = pick_reg();
                        endcase
                        w = {imm, rs1, f3, rd, r2rc_pkg::OP_JALR};
                    end
                    3: begin
                        f3 = ($urandom_range(3) != 0) ? r2rc_pkg::F3_WORD : 3'($urandom);
                        w = {imm, rs1, f3, rd, r2rc_pkg::OP_LOAD};
                    end
                    4: begin
                        f3 = ($urandom_range(3) != 0) ? r2rc_pkg::F3_WORD : 3'($urandom);
                        w = {imm[11:5], rs2, rs1, f3, imm[4:0], r2rc_pkg::OP_STORE};
                    end
                    5: begin
                        off = ($urandom_range(3) != 0) ? 2 * int'($urandom_range(300)) - 300
                                                       : int'($urandom);
                        if ($urandom_range(3) != 0) rs2 = r2rc_pkg::REG_ZERO;
                        case ($urandom_range(2))
                            0: f3 = r2rc_pkg::F3_BEQ;
                            1: f3 = r2rc_pkg::F3_BNE;
                            default: f3 = 3'($urandom);
                        endcase
                        w = branch_word(off, rs1, rs2, f3);
                    end
                    6: begin
                        if ($urandom_range(3) != 0)
                            w = {20'(int'($urandom_range(63)) - 32), rd, r2rc_pkg::OP_LUI};
                        else
                            w = {20'($urandom), rd, r2rc_pkg::OP_LUI};
                    end
                    7: begin
                        off = ($urandom_range(3) != 0) ? 2 * int'($urandom_range(2100)) - 2100
                                                       : int'($urandom);
                        case ($urandom_range(2))
                            0: rd = r2rc_pkg::REG_ZERO;
                            1: rd = r2rc_pkg::REG_RA;
                            default: rd = pick_reg();
                        endcase
                        w = jal_word(off, rd);
                    end
                    8: w = {25'($urandom), KNOWN_OPS[3'($urandom_range(7))]};
                    default: w = $urandom;
                endcase
                issue_word(w, 1'b0, NO_RVC);
            end
        end

        // Drain, then let the pipeline settle before judging.
        i_in_valid <= 1'b0;
        while (rvc_expected.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/r2rc_pkg.sv
rtl/r2rc_encoder.sv
rtl/rv32_to_rvc_compressor_core.sv
test/tb.sv
